// ===== rtl/vn4d_pkg.sv =====
// Shared constants, types and helpers of the 4D value noise pipeline.
`default_nettype none

package vn4d_pkg;

	localparam int COORD_W = 24;
	localparam int FRAC_W  = 16;
	localparam int CELL_W  = COORD_W - FRAC_W;
	localparam int VAL_W   = 16;
	localparam int AXES    = 4;
	localparam int CORNERS = 16;
	localparam int NSTG    = 8;

	// Per-axis hash weights, x first.
	localparam logic [AXES-1:0][17:0] AXIS_K = {18'd67867, 18'd45053, 18'd87811, 18'd12979};
	localparam logic [31:0] HASH_OFFSET = 32'd52967;
	localparam logic [31:0] HASH_MUL    = 32'h5bd1e995;

	typedef struct packed {
		logic [NSTG-1:0] en;
		logic [NSTG-1:0] vld;
	} vn4d_ctl_t;

	// Weight added to the base sum for the corner whose bit i is the +1 step on axis i.
	function automatic logic [31:0] corner_offset(input logic [3:0] idx);
		logic [31:0] r;
		r = 32'd0;
		for (int i = 0; i < AXES; i++) begin
			if (idx[i]) begin
				r = r + {14'd0, AXIS_K[i]};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/vn4d_ctrl.sv =====
// Valid bits and per-stage load enables of the noise pipeline.
`default_nettype none

module vn4d_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              out_ready,
	output vn4d_pkg::vn4d_ctl_t    ctl
);
	import vn4d_pkg::*;

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;

	// A stage loads when it is empty or when the stage after it moves on.
	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || out_ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign ctl.en  = en;
	assign ctl.vld = vld_q;

endmodule

`default_nettype wire

// ===== rtl/vn4d_fade.sv =====
// Smoothstep fade of the four fractions over two pipeline stages.
`default_nettype none

module vn4d_fade (
	input  wire logic                                         clk,
	input  wire vn4d_pkg::vn4d_ctl_t                          ctl,
	input  wire logic [vn4d_pkg::AXES-1:0][vn4d_pkg::FRAC_W-1:0] frac,
	output logic [vn4d_pkg::AXES-1:0][vn4d_pkg::FRAC_W-1:0]      fade
);
	import vn4d_pkg::*;

	logic [AXES-1:0][FRAC_W-1:0] q_s1;
	logic [AXES-1:0][17:0]       t_s1;
	logic [AXES-1:0][FRAC_W-1:0] s_s2;
	logic [AXES-1:0][31:0]       sq;
	logic [AXES-1:0][33:0]       prod;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			sq[i]   = 32'(frac[i]) * 32'(frac[i]);
			prod[i] = 34'(q_s1[i]) * 34'(t_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < AXES; i++) begin
			if (ctl.en[0]) begin
				q_s1[i] <= sq[i][31:16];
				t_s1[i] <= 18'h30000 - {1'b0, frac[i], 1'b0};
			end
			if (ctl.en[1]) begin
				s_s2[i] <= (prod[i][33:32] != 2'd0) ? '1 : prod[i][31:16];
			end
		end
	end

	assign fade = s_s2;

endmodule

`default_nettype wire

// ===== rtl/vn4d_hash.sv =====
// Lattice corner hash: weighted cell sum, xorshift, multiply, xorshift.
`default_nettype none

module vn4d_hash (
	input  wire logic                                            clk,
	input  wire vn4d_pkg::vn4d_ctl_t                             ctl,
	input  wire logic [vn4d_pkg::AXES-1:0][vn4d_pkg::CELL_W-1:0]    cell_idx,
	output logic [vn4d_pkg::CORNERS-1:0][vn4d_pkg::VAL_W-1:0]       corner_val
);
	import vn4d_pkg::*;

	logic [AXES-1:0][25:0]    prod_s1;
	logic [31:0]              base_s2;
	logic [CORNERS-1:0][31:0] hx_s3;
	logic [CORNERS-1:0][30:0] p_s4;

	logic [AXES-1:0][25:0]    prod;
	logic [31:0]              base_sum;
	logic [CORNERS-1:0][31:0] h;
	logic [CORNERS-1:0][31:0] hx;
	logic [CORNERS-1:0][31:0] mul;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			prod[i] = 26'($signed(cell_idx[i]) * $signed(AXIS_K[i]));
		end
		base_sum = HASH_OFFSET;
		for (int i = 0; i < AXES; i++) begin
			base_sum = base_sum + {{6{prod_s1[i][25]}}, prod_s1[i]};
		end
		// The +1 neighbour only adds that axis weight, so each corner is base plus a constant.
		for (int c = 0; c < CORNERS; c++) begin
			h[c]          = base_s2 + corner_offset(4'(c));
			hx[c]         = h[c] ^ (h[c] >> 13);
			mul[c]        = hx_s3[c] * HASH_MUL;
			corner_val[c] = p_s4[c][15:0] ^ p_s4[c][30:15];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			prod_s1 <= prod;
		end
		if (ctl.en[1]) begin
			base_s2 <= base_sum;
		end
		for (int c = 0; c < CORNERS; c++) begin
			if (ctl.en[2]) begin
				hx_s3[c] <= hx[c];
			end
			if (ctl.en[3]) begin
				p_s4[c] <= mul[c][30:0];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vn4d_lerp.sv =====
// One registered level of the interpolation tree: blends neighbouring pairs.
`default_nettype none

module vn4d_lerp #(
	parameter int N_OUT = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  en,
	input  wire logic [vn4d_pkg::FRAC_W-1:0]           fade,
	input  wire logic [2*N_OUT-1:0][vn4d_pkg::VAL_W-1:0] val_in,
	output logic [N_OUT-1:0][vn4d_pkg::VAL_W-1:0]        val_out
);
	import vn4d_pkg::*;

	logic [N_OUT-1:0][VAL_W-1:0] val_q;
	logic [N_OUT-1:0][33:0]      r;
	logic [FRAC_W:0]             wa;

	always_comb begin
		wa = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, fade};
		for (int i = 0; i < N_OUT; i++) begin
			r[i] = 34'(val_in[2*i]) * 34'(wa) + 34'(val_in[2*i+1]) * 34'(fade);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_OUT; i++) begin
				val_q[i] <= r[i][31:16];
			end
		end
	end

	assign val_out = val_q;

endmodule

`default_nettype wire

// ===== rtl/value_noise_4d.sv =====
// Top level of the pipelined 4D value noise generator.
// Usage:
//   The input channel (in_valid/in_ready) carries one point per beat as four
//   signed Q7.16 coordinates. The output channel (out_valid/out_ready) carries
//   one unsigned Q0.16 noise sample per beat, in the order the points came in.
//   The datapath is an eight-stage pipeline: two stages of fade and weighted
//   cell sum, two of corner hashing (the second holds the 32-bit multiplier),
//   then one stage per axis of the interpolation tree, the last being the
//   output register. A new point can be taken in every cycle unless a stalled
//   output has filled the pipeline.
//   Each stage keeps its own valid bit and loads whenever it is empty or the
//   stage after it advances, so bubbles close up under a stall. When the
//   receiver holds out_ready low the full pipeline fills and only then does
//   in_ready fall; nothing is dropped or repeated.
//   Reset clears the valid bits only; the datapath registers are not reset.
`default_nettype none

module value_noise_4d (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [vn4d_pkg::COORD_W-1:0] coord_x,
	input  wire logic signed [vn4d_pkg::COORD_W-1:0] coord_y,
	input  wire logic signed [vn4d_pkg::COORD_W-1:0] coord_z,
	input  wire logic signed [vn4d_pkg::COORD_W-1:0] coord_w,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [vn4d_pkg::VAL_W-1:0]               noise_value
);
	import vn4d_pkg::*;

	vn4d_ctl_t                   ctl;
	logic [AXES-1:0][CELL_W-1:0] cell_idx;
	logic [AXES-1:0][FRAC_W-1:0] frac;
	logic [AXES-1:0][FRAC_W-1:0] fade;
	logic [AXES-1:0][FRAC_W-1:0] s_s3;
	logic [AXES-1:0][FRAC_W-1:0] s_s4;
	logic [AXES-1:0][FRAC_W-1:0] s_s5;
	logic [AXES-1:0][FRAC_W-1:0] s_s6;
	logic [AXES-1:0][FRAC_W-1:0] s_s7;

	logic [CORNERS-1:0][VAL_W-1:0] corner_val;
	logic [7:0][VAL_W-1:0]         vx;
	logic [3:0][VAL_W-1:0]         vy;
	logic [1:0][VAL_W-1:0]         vz;
	logic [0:0][VAL_W-1:0]         vw;

	assign cell_idx = {coord_w[COORD_W-1:FRAC_W], coord_z[COORD_W-1:FRAC_W],
		coord_y[COORD_W-1:FRAC_W], coord_x[COORD_W-1:FRAC_W]};
	assign frac = {coord_w[FRAC_W-1:0], coord_z[FRAC_W-1:0],
		coord_y[FRAC_W-1:0], coord_x[FRAC_W-1:0]};

	vn4d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	vn4d_fade u_fade (
		.clk  (clk),
		.ctl  (ctl),
		.frac (frac),
		.fade (fade)
	);

	vn4d_hash u_hash (
		.clk        (clk),
		.ctl        (ctl),
		.cell_idx   (cell_idx),
		.corner_val (corner_val)
	);

	// Fade weights ride alongside the corner values until their axis is blended.
	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			s_s3 <= fade;
		end
		if (ctl.en[3]) begin
			s_s4 <= s_s3;
		end
		if (ctl.en[4]) begin
			s_s5 <= s_s4;
		end
		if (ctl.en[5]) begin
			s_s6 <= s_s5;
		end
		if (ctl.en[6]) begin
			s_s7 <= s_s6;
		end
	end

	vn4d_lerp #(.N_OUT(8)) u_lerp_x (
		.clk     (clk),
		.en      (ctl.en[4]),
		.fade    (s_s4[0]),
		.val_in  (corner_val),
		.val_out (vx)
	);

	vn4d_lerp #(.N_OUT(4)) u_lerp_y (
		.clk     (clk),
		.en      (ctl.en[5]),
		.fade    (s_s5[1]),
		.val_in  (vx),
		.val_out (vy)
	);

	vn4d_lerp #(.N_OUT(2)) u_lerp_z (
		.clk     (clk),
		.en      (ctl.en[6]),
		.fade    (s_s6[2]),
		.val_in  (vy),
		.val_out (vz)
	);

	vn4d_lerp #(.N_OUT(1)) u_lerp_w (
		.clk     (clk),
		.en      (ctl.en[7]),
		.fade    (s_s7[3]),
		.val_in  (vz),
		.val_out (vw)
	);

	assign in_ready    = ctl.en[0];
	assign out_valid   = ctl.vld[NSTG-1];
	assign noise_value = vw[0];

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused while the output register is empty");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input refused without a stalled output beat");

	a_beat_enters_stage1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> ctl.vld[0])
		else $error("accepted beat did not reach the first stage");

endmodule

`default_nettype wire
